// ===== hw/rtl/tbn_pkg.sv =====
// ----------------------------------------------------------------------------
// tbn_pkg: shared types and role logic for the tournament barrier node
// Holds sizes, codes, command and role types, and the per-round role function.
// ----------------------------------------------------------------------------
`default_nettype none

package tbn_pkg;

    localparam int MAX_NODES   = 64;
    localparam int ROUND_COUNT = 7;
    localparam int RANK_W      = 6;
    localparam int COUNT_W     = 7;
    localparam int ROUND_W     = $clog2(ROUND_COUNT + 1);
    localparam int PW          = COUNT_W + 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic OP_ENTER     = 1'b0;
    localparam logic OP_MESSAGE   = 1'b1;
    localparam logic KIND_SEND    = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;
    localparam logic CFG_NODE_COUNT = 1'b0;
    localparam logic CFG_MY_RANK    = 1'b1;

    typedef enum logic [2:0] {
        ROLE_WINNER,
        ROLE_LOSER,
        ROLE_CHAMPION,
        ROLE_BYE,
        ROLE_UNUSED
    } role_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAIT_IN,
        PH_WAIT_WAKE
    } phase_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_CLIMB,
        BK_WAKE
    } bk_state_t;

    typedef struct packed {
        role_t               role;
        logic [RANK_W-1:0]   opp;
    } role_info_t;

    typedef struct packed {
        logic                op;
        logic [ROUND_W-1:0]  round;
    } cmd_t;

    function automatic logic [COUNT_W-1:0] eff_nodes(input logic [COUNT_W-1:0] n);
        logic [COUNT_W-1:0] r;
        if (n == '0)
            r = COUNT_W'(1);
        else if (n > COUNT_W'(MAX_NODES))
            r = COUNT_W'(MAX_NODES);
        else
            r = n;
        return r;
    endfunction

    function automatic role_info_t role_of(input logic [ROUND_W-1:0] k,
                                           input logic [COUNT_W-1:0] n,
                                           input logic [RANK_W-1:0]  i);
        logic [PW-1:0] p;
        logic [PW-1:0] h;
        logic [PW-1:0] iw;
        logic [PW-1:0] nw;
        logic [PW-1:0] lo;
        logic [PW-1:0] sum;
        logic [PW-1:0] diff;
        role_info_t    r;
        p    = PW'(1) << k;
        h    = p >> 1;
        iw   = PW'(i);
        nw   = PW'(n);
        lo   = iw & (p - PW'(1));
        sum  = iw + h;
        diff = iw - h;
        r.role = ROLE_UNUSED;
        r.opp  = '0;
        if (lo == '0 && sum < nw && p < nw) begin
            r.role = ROLE_WINNER;
            r.opp  = sum[RANK_W-1:0];
        end else if (lo == '0 && sum >= nw) begin
            r.role = ROLE_BYE;
        end else if (lo == h) begin
            r.role = ROLE_LOSER;
            r.opp  = diff[RANK_W-1:0];
        end else if (i == '0 && p >= nw) begin
            r.role = ROLE_CHAMPION;
            r.opp  = h[RANK_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tbn_front.sv =====
// ----------------------------------------------------------------------------
// tbn_front: input acceptance and classification
// Accepts items, finds the round of a peer message and queues a command.
// ----------------------------------------------------------------------------
`default_nettype none

module tbn_front (
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic                         operation,
    input  wire logic [tbn_pkg::RANK_W-1:0]   source_rank,
    input  wire logic [tbn_pkg::COUNT_W-1:0]  node_count,
    input  wire logic [tbn_pkg::RANK_W-1:0]   my_rank,
    input  wire logic                         q_full,
    output logic                              q_push,
    output tbn_pkg::cmd_t                     q_cmd
);

    logic [tbn_pkg::COUNT_W-1:0] n_eff;
    logic                        hit;
    logic [tbn_pkg::ROUND_W-1:0] hit_round;
    tbn_pkg::role_info_t         ri;

    assign n_eff = tbn_pkg::eff_nodes(node_count);

    // first round whose opponent sent the message
    always_comb
    begin
        hit       = 1'b0;
        hit_round = '0;
        ri        = '{role: tbn_pkg::ROLE_UNUSED, opp: '0};
        for (int k = 1; k < tbn_pkg::ROUND_COUNT; k++)
        begin
            ri = tbn_pkg::role_of(tbn_pkg::ROUND_W'(k), n_eff, my_rank);
            if (!hit && ri.opp == source_rank &&
                (ri.role == tbn_pkg::ROLE_WINNER || ri.role == tbn_pkg::ROLE_LOSER ||
                 ri.role == tbn_pkg::ROLE_CHAMPION))
            begin
                hit       = 1'b1;
                hit_round = tbn_pkg::ROUND_W'(k);
            end
        end
    end

    assign in_stall    = q_full;
    assign q_push      = in_valid && !q_full && (operation == tbn_pkg::OP_ENTER || hit);
    assign q_cmd.op    = operation;
    assign q_cmd.round = hit_round;

endmodule

`default_nettype wire

// ===== hw/rtl/tbn_queue.sv =====
// ----------------------------------------------------------------------------
// tbn_queue: command queue between front and back
// Small first-in first-out buffer of classified commands.
// ----------------------------------------------------------------------------
`default_nettype none

module tbn_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire tbn_pkg::cmd_t  push_cmd,
    input  wire logic           pop,
    output tbn_pkg::cmd_t       head_cmd,
    output logic                not_empty,
    output logic                full
);

    tbn_pkg::cmd_t                  entry_reg [tbn_pkg::QUEUE_DEPTH];
    logic [tbn_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [tbn_pkg::QPTR_W-1:0]     wr_ptr_next;
    logic [tbn_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [tbn_pkg::QPTR_W-1:0]     rd_ptr_next;
    logic [tbn_pkg::QCNT_W-1:0]     count_reg;
    logic [tbn_pkg::QCNT_W-1:0]     count_next;

    assign not_empty = count_reg != '0;
    assign full      = count_reg == tbn_pkg::QCNT_W'(tbn_pkg::QUEUE_DEPTH);
    assign head_cmd  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == tbn_pkg::QPTR_W'(tbn_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + tbn_pkg::QPTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == tbn_pkg::QPTR_W'(tbn_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + tbn_pkg::QPTR_W'(1);
        if (push && !pop)
            count_next = count_reg + tbn_pkg::QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - tbn_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tbn_back.sv =====
// ----------------------------------------------------------------------------
// tbn_back: barrier walk sequencer
// Runs the arrival climb and the wake-up walk, one round per cycle while the
// output is not stalled, and holds the barrier state and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tbn_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [tbn_pkg::COUNT_W-1:0]  node_count,
    input  wire logic [tbn_pkg::RANK_W-1:0]   my_rank,
    input  wire tbn_pkg::cmd_t                q_cmd,
    input  wire logic                         q_valid,
    output logic                              q_pop,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic                              kind,
    output logic [tbn_pkg::RANK_W-1:0]        dest_rank,
    output logic                              sense_value,
    output logic                              last
);

    tbn_pkg::bk_state_t            st_reg;
    tbn_pkg::bk_state_t            st_next;
    logic [tbn_pkg::ROUND_W-1:0]   k_reg;
    logic [tbn_pkg::ROUND_W-1:0]   k_next;
    tbn_pkg::phase_t               phase_reg;
    tbn_pkg::phase_t               phase_next;
    logic [tbn_pkg::ROUND_W-1:0]   cur_reg;
    logic [tbn_pkg::ROUND_W-1:0]   cur_next;
    logic                          sense_reg;
    logic                          sense_next;
    logic [tbn_pkg::ROUND_COUNT-1:0] arrived_reg;
    logic [tbn_pkg::ROUND_COUNT-1:0] arrived_next;
    logic                          out_valid_reg;
    logic                          kind_reg;
    logic [tbn_pkg::RANK_W-1:0]    dest_reg;
    logic                          sense_out_reg;
    logic                          last_reg;

    logic                          adv;
    logic                          emit;
    logic                          e_kind;
    logic [tbn_pkg::RANK_W-1:0]    e_dest;
    logic                          e_last;
    logic [tbn_pkg::COUNT_W-1:0]   n_eff;
    logic                          lone;
    logic                          climb_end;
    logic                          arr_k;
    logic                          consume;
    logic [tbn_pkg::ROUND_W-1:0]   k_dn;
    tbn_pkg::role_info_t           k_role;
    tbn_pkg::role_info_t           dn_role;
    tbn_pkg::role_info_t           q_role;

    assign adv       = !out_valid_reg || !out_stall;
    assign n_eff     = tbn_pkg::eff_nodes(node_count);
    assign lone      = n_eff == tbn_pkg::COUNT_W'(1) || tbn_pkg::COUNT_W'(my_rank) >= n_eff;
    assign climb_end = k_reg >= tbn_pkg::ROUND_W'(tbn_pkg::ROUND_COUNT);
    assign arr_k     = climb_end ? 1'b0 : arrived_reg[k_reg];
    assign k_dn      = k_reg - tbn_pkg::ROUND_W'(1);
    assign k_role    = tbn_pkg::role_of(k_reg, n_eff, my_rank);
    assign dn_role   = tbn_pkg::role_of(k_dn, n_eff, my_rank);
    assign q_role    = tbn_pkg::role_of(q_cmd.round, n_eff, my_rank);
    assign consume   = phase_reg != tbn_pkg::PH_IDLE && q_cmd.round == cur_reg;
    assign q_pop     = adv && st_reg == tbn_pkg::BK_IDLE && q_valid;

    // next state
    always_comb
    begin
        st_next = st_reg;
        k_next  = k_reg;
        if (adv)
        begin
            unique case (st_reg)
                tbn_pkg::BK_IDLE:
                begin
                    if (q_valid)
                    begin
                        if (q_cmd.op == tbn_pkg::OP_ENTER)
                        begin
                            if (phase_reg == tbn_pkg::PH_IDLE)
                            begin
                                if (lone)
                                begin
                                    st_next = tbn_pkg::BK_WAKE;
                                    k_next  = '0;
                                end
                                else
                                begin
                                    st_next = tbn_pkg::BK_CLIMB;
                                    k_next  = tbn_pkg::ROUND_W'(1);
                                end
                            end
                        end
                        else if (consume)
                        begin
                            if (phase_reg == tbn_pkg::PH_WAIT_WAKE ||
                                q_role.role == tbn_pkg::ROLE_CHAMPION)
                            begin
                                st_next = tbn_pkg::BK_WAKE;
                                k_next  = q_cmd.round;
                            end
                            else
                            begin
                                st_next = tbn_pkg::BK_CLIMB;
                                k_next  = q_cmd.round + tbn_pkg::ROUND_W'(1);
                            end
                        end
                    end
                end
                tbn_pkg::BK_CLIMB:
                begin
                    if (climb_end)
                        st_next = tbn_pkg::BK_WAKE;
                    else
                    begin
                        unique case (k_role.role)
                            tbn_pkg::ROLE_WINNER:
                            begin
                                if (arr_k)
                                    k_next = k_reg + tbn_pkg::ROUND_W'(1);
                                else
                                    st_next = tbn_pkg::BK_IDLE;
                            end
                            tbn_pkg::ROLE_LOSER, tbn_pkg::ROLE_CHAMPION:
                                st_next = arr_k ? tbn_pkg::BK_WAKE : tbn_pkg::BK_IDLE;
                            default:
                                k_next = k_reg + tbn_pkg::ROUND_W'(1);
                        endcase
                    end
                end
                tbn_pkg::BK_WAKE:
                begin
                    if (k_reg > tbn_pkg::ROUND_W'(1))
                        k_next = k_dn;
                    else
                        st_next = tbn_pkg::BK_IDLE;
                end
                default:
                    st_next = tbn_pkg::BK_IDLE;
            endcase
        end
    end

    // results and barrier state
    always_comb
    begin
        emit         = 1'b0;
        e_kind       = tbn_pkg::KIND_SEND;
        e_dest       = '0;
        e_last       = 1'b0;
        phase_next   = phase_reg;
        cur_next     = cur_reg;
        sense_next   = sense_reg;
        arrived_next = arrived_reg;
        if (adv)
        begin
            unique case (st_reg)
                tbn_pkg::BK_IDLE:
                begin
                    if (q_valid && q_cmd.op == tbn_pkg::OP_MESSAGE)
                    begin
                        arrived_next[q_cmd.round] = !consume;
                        if (consume && phase_reg != tbn_pkg::PH_WAIT_WAKE &&
                            q_role.role == tbn_pkg::ROLE_CHAMPION)
                        begin
                            emit   = 1'b1;
                            e_dest = q_role.opp;
                        end
                    end
                end
                tbn_pkg::BK_CLIMB:
                begin
                    if (!climb_end)
                    begin
                        unique case (k_role.role)
                            tbn_pkg::ROLE_WINNER:
                            begin
                                if (arr_k)
                                    arrived_next[k_reg] = 1'b0;
                                else
                                begin
                                    phase_next = tbn_pkg::PH_WAIT_IN;
                                    cur_next   = k_reg;
                                end
                            end
                            tbn_pkg::ROLE_LOSER:
                            begin
                                emit   = 1'b1;
                                e_dest = k_role.opp;
                                if (arr_k)
                                    arrived_next[k_reg] = 1'b0;
                                else
                                begin
                                    e_last     = 1'b1;
                                    phase_next = tbn_pkg::PH_WAIT_WAKE;
                                    cur_next   = k_reg;
                                end
                            end
                            tbn_pkg::ROLE_CHAMPION:
                            begin
                                if (arr_k)
                                begin
                                    arrived_next[k_reg] = 1'b0;
                                    emit   = 1'b1;
                                    e_dest = k_role.opp;
                                end
                                else
                                begin
                                    phase_next = tbn_pkg::PH_WAIT_IN;
                                    cur_next   = k_reg;
                                end
                            end
                            default:
                                emit = 1'b0;
                        endcase
                    end
                end
                tbn_pkg::BK_WAKE:
                begin
                    if (k_reg > tbn_pkg::ROUND_W'(1))
                    begin
                        if (dn_role.role == tbn_pkg::ROLE_WINNER)
                        begin
                            emit   = 1'b1;
                            e_dest = dn_role.opp;
                        end
                    end
                    else
                    begin
                        emit       = 1'b1;
                        e_kind     = tbn_pkg::KIND_RELEASE;
                        e_last     = 1'b1;
                        sense_next = !sense_reg;
                        phase_next = tbn_pkg::PH_IDLE;
                        cur_next   = '0;
                    end
                end
                default:
                    emit = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= tbn_pkg::BK_IDLE;
            k_reg         <= '0;
            phase_reg     <= tbn_pkg::PH_IDLE;
            cur_reg       <= '0;
            sense_reg     <= 1'b0;
            arrived_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg      <= st_next;
            k_reg       <= k_next;
            phase_reg   <= phase_next;
            cur_reg     <= cur_next;
            sense_reg   <= sense_next;
            arrived_reg <= arrived_next;
            if (adv)
                out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && emit)
        begin
            kind_reg      <= e_kind;
            dest_reg      <= e_dest;
            sense_out_reg <= sense_reg;
            last_reg      <= e_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign dest_rank   = dest_reg;
    assign sense_value = sense_out_reg;
    assign last        = last_reg;

    a_release_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == tbn_pkg::KIND_RELEASE) |-> last_reg)
        else $error("release result not marked last");

    a_idle_round: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == tbn_pkg::PH_IDLE) |-> (cur_reg == '0))
        else $error("idle phase with a pending round");

    a_sense_toggle: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && st_reg == tbn_pkg::BK_WAKE && k_reg <= tbn_pkg::ROUND_W'(1))
        |=> (sense_reg != $past(sense_reg)))
        else $error("sense not toggled on release");

    a_walk_holds_output: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (st_reg == $past(st_reg) && k_reg == $past(k_reg)))
        else $error("walk advanced while result was stalled");

endmodule

`default_nettype wire

// ===== hw/rtl/tournament_barrier_node_core.sv =====
// ----------------------------------------------------------------------------
// tournament_barrier_node_core: one participant of a tournament barrier
// Input channel (in_valid/in_stall): operation 0 enters the barrier,
// operation 1 delivers a peer message with its source_rank. Output channel
// (out_valid/out_stall): each transfer is a send to dest_rank or a release,
// with the episode's sense bit and last set on the final result of an item.
// Config port: cfg_we with cfg_index 0 = node_count, 1 = my_rank; write
// only while the block is idle.
// An accepted item goes into a two-entry command queue; the walk sequencer
// takes it once idle and visits one round per cycle while the output is not
// stalled, emitting at most one result per cycle into the output register.
// An item holds the sequencer to leave the queue, for a climb over up to six
// rounds and the top check and for a wake-up walk over up to six rounds and
// the release, and gives up to 7 results. The round walk sets the rate;
// items are handled one at a time. While out_stall holds a result the walk
// holds; in_stall rises once the queue fills.
// Reset: node_count 1, my_rank 0, sense 0, no arrivals held, queue empty.
// ----------------------------------------------------------------------------
`default_nettype none

module tournament_barrier_node_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic                         cfg_index,
    input  wire logic [tbn_pkg::COUNT_W-1:0]  cfg_data,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic                         operation,
    input  wire logic [tbn_pkg::RANK_W-1:0]   source_rank,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic                              kind,
    output logic [tbn_pkg::RANK_W-1:0]        dest_rank,
    output logic                              sense_value,
    output logic                              last
);

    logic [tbn_pkg::COUNT_W-1:0] node_count_reg;
    logic [tbn_pkg::RANK_W-1:0]  my_rank_reg;
    logic                        q_push;
    logic                        q_pop;
    logic                        q_full;
    logic                        q_valid;
    tbn_pkg::cmd_t               push_cmd;
    tbn_pkg::cmd_t               head_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= tbn_pkg::COUNT_W'(1);
            my_rank_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tbn_pkg::CFG_NODE_COUNT: node_count_reg <= cfg_data;
                tbn_pkg::CFG_MY_RANK:    my_rank_reg    <= cfg_data[tbn_pkg::RANK_W-1:0];
                default:                 my_rank_reg    <= my_rank_reg;
            endcase
        end
    end

    tbn_front u_front (
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .source_rank (source_rank),
        .node_count  (node_count_reg),
        .my_rank     (my_rank_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (push_cmd)
    );

    tbn_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .pop       (q_pop),
        .head_cmd  (head_cmd),
        .not_empty (q_valid),
        .full      (q_full)
    );

    tbn_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .node_count  (node_count_reg),
        .my_rank     (my_rank_reg),
        .q_cmd       (head_cmd),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .dest_rank   (dest_rank),
        .sense_value (sense_value),
        .last        (last)
    );

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for the tournament barrier node core
// Drives enter and peer message items over the valid/stall input channel and
// checks every result transfer against an in-bench model of the node's round
// walk. Directed items cover the corner settings; random barrier episodes with
// shuffled, early, repeated, missing and stray messages follow, with random
// idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

    localparam int MAX_RESULTS    = 8;
    localparam int HOLD_LEN       = 300;
    localparam int QUIET_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_ITEMS   = 360;

    typedef struct packed {
        logic                      kind;
        logic [tbn_pkg::RANK_W-1:0] dest;
        logic                      sense;
        logic                      last;
    } barrier_result_t;

    class barrier_scoreboard;
        logic [tbn_pkg::COUNT_W-1:0] node_count;
        logic [tbn_pkg::RANK_W-1:0]  my_rank;
        logic                        sense;
        tbn_pkg::phase_t             phase;
        int                          wait_round;
        bit                          arrived[tbn_pkg::ROUND_COUNT];
        barrier_result_t             pending[$];
        barrier_result_t             expected[$];
        int                          errors;

        function new();
            node_count = tbn_pkg::COUNT_W'(1);
            my_rank    = '0;
            sense      = 1'b0;
            phase      = tbn_pkg::PH_IDLE;
            wait_round = 0;
            errors     = 0;
            foreach (arrived[k])
                arrived[k] = 1'b0;
        endfunction

        function void set_regs(logic [tbn_pkg::COUNT_W-1:0] n, logic [tbn_pkg::RANK_W-1:0] r);
            node_count = n;
            my_rank    = r;
        endfunction

        function int active_nodes();
            if (node_count == 0)
                return 1;
            if (node_count > tbn_pkg::MAX_NODES)
                return tbn_pkg::MAX_NODES;
            return node_count;
        endfunction

        function tbn_pkg::role_t round_role(int k, output int opp);
            int n;
            int i;
            int p;
            int h;
            n   = active_nodes();
            i   = my_rank;
            p   = 1 << k;
            h   = p >> 1;
            opp = 0;
            if (i % p == 0 && i + h < n && p < n)
            begin
                opp = i + h;
                return tbn_pkg::ROLE_WINNER;
            end
            if (i % p == 0 && i + h >= n)
                return tbn_pkg::ROLE_BYE;
            if (i % p == h)
            begin
                opp = i - h;
                return tbn_pkg::ROLE_LOSER;
            end
            if (i == 0 && p >= n)
            begin
                opp = h;
                return tbn_pkg::ROLE_CHAMPION;
            end
            return tbn_pkg::ROLE_UNUSED;
        endfunction

        function void push_result(logic k, int dest);
            barrier_result_t r;
            if (pending.size() >= MAX_RESULTS)
                return;
            r.kind  = k;
            r.dest  = tbn_pkg::RANK_W'(dest);
            r.sense = sense;
            r.last  = 1'b0;
            pending.push_back(r);
        endfunction

        function void release_barrier();
            push_result(tbn_pkg::KIND_RELEASE, 0);
            sense      = ~sense;
            phase      = tbn_pkg::PH_IDLE;
            wait_round = 0;
        endfunction

        function void wake_walk(int from);
            int k;
            int opp;
            for (k = from; k > 1; k--)
            begin
                if (round_role(k - 1, opp) == tbn_pkg::ROLE_WINNER)
                    push_result(tbn_pkg::KIND_SEND, opp);
            end
            release_barrier();
        endfunction

        function void climb(int start);
            int              k;
            int              opp;
            tbn_pkg::role_t  role;
            for (k = start; k < tbn_pkg::ROUND_COUNT; k++)
            begin
                role = round_role(k, opp);
                if (role == tbn_pkg::ROLE_WINNER)
                begin
                    if (arrived[k])
                        arrived[k] = 1'b0;
                    else
                    begin
                        phase      = tbn_pkg::PH_WAIT_IN;
                        wait_round = k;
                        return;
                    end
                end
                else if (role == tbn_pkg::ROLE_LOSER)
                begin
                    push_result(tbn_pkg::KIND_SEND, opp);
                    if (arrived[k])
                    begin
                        arrived[k] = 1'b0;
                        wake_walk(k);
                    end
                    else
                    begin
                        phase      = tbn_pkg::PH_WAIT_WAKE;
                        wait_round = k;
                    end
                    return;
                end
                else if (role == tbn_pkg::ROLE_CHAMPION)
                begin
                    if (arrived[k])
                    begin
                        arrived[k] = 1'b0;
                        push_result(tbn_pkg::KIND_SEND, opp);
                        wake_walk(k);
                    end
                    else
                    begin
                        phase      = tbn_pkg::PH_WAIT_IN;
                        wait_round = k;
                    end
                    return;
                end
            end
            // ran past the top round without stopping
            wake_walk(tbn_pkg::ROUND_COUNT);
        endfunction

        function void note_input(logic op, logic [tbn_pkg::RANK_W-1:0] src);
            int              k;
            int              opp;
            int              hit;
            tbn_pkg::role_t  role;
            pending.delete();
            if (op == tbn_pkg::OP_ENTER)
            begin
                if (phase == tbn_pkg::PH_IDLE)
                begin
                    if (active_nodes() == 1 || my_rank >= active_nodes())
                        release_barrier();
                    else
                        climb(1);
                end
            end
            else
            begin
                hit = 0;
                for (k = 1; k < tbn_pkg::ROUND_COUNT && hit == 0; k++)
                begin
                    role = round_role(k, opp);
                    if (role != tbn_pkg::ROLE_BYE && role != tbn_pkg::ROLE_UNUSED &&
                        opp == src)
                        hit = k;
                end
                if (hit != 0)
                begin
                    arrived[hit] = 1'b1;
                    if (phase != tbn_pkg::PH_IDLE && hit == wait_round)
                    begin
                        arrived[hit] = 1'b0;
                        if (phase == tbn_pkg::PH_WAIT_WAKE)
                            wake_walk(hit);
                        else if (round_role(hit, opp) == tbn_pkg::ROLE_CHAMPION)
                        begin
                            push_result(tbn_pkg::KIND_SEND, opp);
                            wake_walk(hit);
                        end
                        else
                            climb(hit + 1);
                    end
                end
            end
            if (pending.size() > 0)
                pending[pending.size() - 1].last = 1'b1;
            foreach (pending[j])
                expected.push_back(pending[j]);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic k, logic [tbn_pkg::RANK_W-1:0] d, logic s, logic l);
            barrier_result_t want;
            if (expected.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, %s %0d dest %0d %s %0d %s %0d",
                         $time, "actual kind", k, d, "sense", s, "last", l);
                errors++;
                return;
            end
            want = expected.pop_front();
            compare_field("kind", 8'(want.kind), 8'(k));
            compare_field("dest_rank", 8'(want.dest), 8'(d));
            compare_field("sense_value", 8'(want.sense), 8'(s));
            compare_field("last", 8'(want.last), 8'(l));
        endfunction
    endclass

    logic                        clk          = 1'b0;
    logic                        rst_n        = 1'b0;
    logic                        cfg_we       = 1'b0;
    logic                        cfg_index    = tbn_pkg::CFG_NODE_COUNT;
    logic [tbn_pkg::COUNT_W-1:0] cfg_data     = '0;
    logic                        in_valid     = 1'b0;
    logic                        operation    = tbn_pkg::OP_ENTER;
    logic [tbn_pkg::RANK_W-1:0]  source_rank  = '0;
    logic                        out_stall    = 1'b0;
    logic                        hold_req     = 1'b0;
    logic                        hold_done    = 1'b0;
    int                          hold_left    = 0;
    int                          idle_cycles  = 0;
    bit                          gaps_on      = 1'b1;
    bit                          stall_on     = 1'b1;

    wire                         in_stall;
    wire                         out_valid;
    wire                         kind;
    wire [tbn_pkg::RANK_W-1:0]   dest_rank;
    wire                         sense_value;
    wire                         last;

    barrier_scoreboard  sb = new();

    tournament_barrier_node_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .source_rank (source_rank),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .dest_rank   (dest_rank),
        .sense_value (sense_value),
        .last        (last)
    );

    always #5 clk = ~clk;

    // receiver side: random stall, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
            out_stall <= 1'b1;
        end
        else
            out_stall <= stall_on && ($urandom_range(99) < 7);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result(kind, dest_rank, sense_value, last);
            if (in_valid && !in_stall)
                sb.note_input(operation, source_rank);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("*** FAILED ***");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic send_item(input logic op, input logic [tbn_pkg::RANK_W-1:0] src);
        if (gaps_on && $urandom_range(99) < 7)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        source_rank <= src;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [tbn_pkg::COUNT_W-1:0] n,
                              input logic [tbn_pkg::RANK_W-1:0] r);
        cfg_we    <= 1'b1;
        cfg_index <= tbn_pkg::CFG_NODE_COUNT;
        cfg_data  <= n;
        @(posedge clk);
        cfg_index <= tbn_pkg::CFG_MY_RANK;
        cfg_data  <= tbn_pkg::COUNT_W'(r);
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_regs(n, r);
    endtask

    initial
    begin
        int                          produced;
        int                          episode;
        int                          k;
        int                          j;
        int                          m;
        int                          t;
        int                          opp;
        int                          nn;
        int                          enter_at;
        int                          drop_at;
        int                          opps[$];
        int                          early[$];
        logic [tbn_pkg::COUNT_W-1:0] n_cfg;
        logic [tbn_pkg::RANK_W-1:0]  r_cfg;
        tbn_pkg::role_t              role;

        produced = 0;
        episode  = 0;
        early    = '{32, 16, 8, 4, 2, 1, 1};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: single node, stray message dropped
        send_item(tbn_pkg::OP_ENTER, 6'd0);
        send_item(tbn_pkg::OP_MESSAGE, 6'd63);
        drain();

        // zero node count acts as one
        set_config(7'd0, 6'd0);
        send_item(tbn_pkg::OP_ENTER, 6'd0);
        drain();

        // saturated count, top rank loses round one; enter while busy ignored
        set_config(7'd127, 6'd63);
        send_item(tbn_pkg::OP_ENTER, 6'd0);
        send_item(tbn_pkg::OP_ENTER, 6'd5);
        send_item(tbn_pkg::OP_MESSAGE, 6'd0);
        send_item(tbn_pkg::OP_MESSAGE, 6'd62);
        drain();

        // champion with every message early, one repeated
        set_config(7'd64, 6'd0);
        foreach (early[i])
            send_item(tbn_pkg::OP_MESSAGE, 6'(early[i]));
        send_item(tbn_pkg::OP_ENTER, 6'd0);
        drain();

        // rank changed mid-walk so the climb runs past the top round
        set_config(7'd64, 6'd0);
        send_item(tbn_pkg::OP_ENTER, 6'd0);
        drain();
        set_config(7'd64, 6'd1);
        send_item(tbn_pkg::OP_MESSAGE, 6'd0);
        drain();

        // rank outside the node count
        set_config(7'd4, 6'd10);
        send_item(tbn_pkg::OP_ENTER, 6'd0);
        drain();

        // loser in the top round, full wake-up walk back down
        set_config(7'd64, 6'd32);
        send_item(tbn_pkg::OP_ENTER, 6'd0);
        send_item(tbn_pkg::OP_MESSAGE, 6'd33);
        send_item(tbn_pkg::OP_MESSAGE, 6'd34);
        send_item(tbn_pkg::OP_MESSAGE, 6'd36);
        send_item(tbn_pkg::OP_MESSAGE, 6'd40);
        send_item(tbn_pkg::OP_MESSAGE, 6'd48);
        send_item(tbn_pkg::OP_MESSAGE, 6'd0);
        drain();

        while (produced < RANDOM_ITEMS)
        begin
            if (episode % 4 == 0 || $urandom_range(5) == 0)
            begin
                drain();
                case ($urandom_range(9))
                    0: n_cfg = 7'd0;
                    1: n_cfg = 7'($urandom_range(65, 127));
                    2: n_cfg = 7'd64;
                    3: n_cfg = 7'd1;
                    4: n_cfg = 7'd2;
                    default: n_cfg = 7'($urandom_range(3, 64));
                endcase
                nn = (n_cfg == 0) ? 1 :
                     ((n_cfg > tbn_pkg::MAX_NODES) ? tbn_pkg::MAX_NODES : n_cfg);
                if ($urandom_range(9) == 0)
                    r_cfg = 6'($urandom_range(63));
                else
                    r_cfg = 6'($urandom_range(nn - 1));
                set_config(n_cfg, r_cfg);
            end
            if (episode == 12)
                hold_req <= 1'b1;
            gaps_on  = !(episode >= 40 && episode < 55);
            stall_on = gaps_on;

            // messages this node needs from its opponents, up to where it stops
            opps.delete();
            if (sb.active_nodes() > 1 && sb.my_rank < sb.active_nodes())
            begin
                for (k = 1; k < tbn_pkg::ROUND_COUNT; k++)
                begin
                    role = sb.round_role(k, opp);
                    if (role == tbn_pkg::ROLE_WINNER)
                        opps.push_back(opp);
                    else if (role == tbn_pkg::ROLE_LOSER || role == tbn_pkg::ROLE_CHAMPION)
                    begin
                        opps.push_back(opp);
                        break;
                    end
                end
            end
            if ($urandom_range(1))
            begin
                for (j = opps.size() - 1; j > 0; j--)
                begin
                    k       = $urandom_range(j);
                    t       = opps[j];
                    opps[j] = opps[k];
                    opps[k] = t;
                end
            end
            enter_at = ($urandom_range(9) < 7) ? 0 : $urandom_range(opps.size());
            drop_at  = ($urandom_range(19) == 0) ? $urandom_range(opps.size()) : -1;

            m = 0;
            for (j = 0; j <= opps.size(); j++)
            begin
                if ($urandom_range(9) == 0)
                begin
                    if ($urandom_range(1))
                        send_item(tbn_pkg::OP_ENTER, 6'($urandom));
                    else
                        send_item(tbn_pkg::OP_MESSAGE, 6'($urandom));
                end
                if (j == enter_at)
                begin
                    send_item(tbn_pkg::OP_ENTER, 6'($urandom));
                    produced++;
                end
                else
                begin
                    if (m != drop_at)
                    begin
                        send_item(tbn_pkg::OP_MESSAGE, 6'(opps[m]));
                        produced++;
                    end
                    m++;
                end
            end
            episode++;
        end

        drain();
        if (sb.errors == 0 && sb.expected.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
